@@ design/cpr_pkg.sv @@
// Shared types, constants and fixed-point helpers for the charged particle push unit.
package cpr_pkg;

	localparam int VAL_W  = 24;
	localparam int KICK_W = 15;
	localparam int TRIG_W = 16;
	localparam int DT_W   = 16;
	localparam int WIDE_W = 48;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [KICK_W-1:0] kick_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic        [DT_W-1:0]   dt_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam val_t VAL_MAX = 24'sh7FFFFF;
	localparam val_t VAL_MIN = 24'sh800000;

	// 0.995 in unsigned Q0.16, held as a positive signed value for the multiplier.
	localparam logic signed [17:0] DAMP_Q16 = 18'sd65208;

	localparam logic [4:0] DT_SHIFT   = 5'd16;
	localparam logic [4:0] DAMP_SHIFT = 5'd16;
	localparam logic [4:0] TRIG_SHIFT = 5'd14;

	typedef enum logic [2:0] {
		IDX_STEP_DT = 3'd0,
		IDX_ROT_COS = 3'd1,
		IDX_ROT_SIN = 3'd2,
		IDX_X_MIN   = 3'd3,
		IDX_X_MAX   = 3'd4,
		IDX_Y_MIN   = 3'd5,
		IDX_Y_MAX   = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		dt_t   step_dt;
		trig_t rot_cos;
		trig_t rot_sin;
		val_t  x_min;
		val_t  x_max;
		val_t  y_min;
		val_t  y_max;
	} cpr_cfg_t;

	typedef struct packed {
		val_t pos;
		val_t vel;
	} pv_t;

	// Clamp a wide signed value into the 24-bit range.
	function automatic val_t sat_val(input wide_t a);
		val_t r;
		if (a > 48'sd8388607) begin
			r = VAL_MAX;
		end else if (a < -48'sd8388608) begin
			r = VAL_MIN;
		end else begin
			r = a[VAL_W-1:0];
		end
		return r;
	endfunction

	// Round to nearest by 2^n, halves going up; the arithmetic shift floors.
	function automatic wide_t rnd_sh(input wide_t a, input logic [4:0] n);
		wide_t half;
		half = 48'sd1 <<< (n - 5'd1);
		return (a + half) >>> n;
	endfunction

	function automatic val_t neg_sat(input val_t v);
		wide_t w;
		w = WIDE_W'(v);
		return sat_val(-w);
	endfunction

	// Minimum wall first, then maximum; each clamps and reflects when its wall is crossed.
	function automatic pv_t wall(input val_t p, input val_t v, input val_t lo,
			input val_t hi);
		val_t pw;
		val_t vw;
		pv_t  r;
		pw = p;
		vw = v;
		if (pw < lo) begin
			pw = lo;
			vw = neg_sat(vw);
		end
		if (pw > hi) begin
			pw = hi;
			vw = neg_sat(vw);
		end
		r.pos = pw;
		r.vel = vw;
		return r;
	endfunction

endpackage

@@ design/cpr_cfg_regs.sv @@
// Configuration register file for the charged particle push unit.
module cpr_cfg_regs
	import cpr_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [23:0]    cfg_data,
	output cpr_cfg_t       cfg
);

	cpr_cfg_t cfg_q;
	logic     wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_dt <= 16'd1092;
			cfg_q.rot_cos <= 16'sd16384;
			cfg_q.rot_sin <= 16'sd0;
			cfg_q.x_min   <= 24'sd0;
			cfg_q.x_max   <= 24'sd163840;
			cfg_q.y_min   <= 24'sd0;
			cfg_q.y_max   <= 24'sd163840;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				IDX_STEP_DT: cfg_q.step_dt <= cfg_data[15:0];
				IDX_ROT_COS: cfg_q.rot_cos <= cfg_data[15:0];
				IDX_ROT_SIN: cfg_q.rot_sin <= cfg_data[15:0];
				IDX_X_MIN:   cfg_q.x_min   <= cfg_data;
				IDX_X_MAX:   cfg_q.x_max   <= cfg_data;
				IDX_Y_MIN:   cfg_q.y_min   <= cfg_data;
				IDX_Y_MAX:   cfg_q.y_max   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ design/charged_particle_rotation_push_unit.sv @@
// Top level of the charged particle push unit: nine-stage particle update pipeline.
//
// Channel | Direction | Handshake               | Contents
// --------+-----------+-------------------------+-----------------------------------------
// s_axis  | in        | tvalid / tready         | particle state, kicks, charge flag
// m_axis  | out       | tvalid / tready         | updated position and velocity
// cfg     | in        | cfg_valid / cfg_ready   | register index and write data
//
// An item is accepted every cycle while the output is not stalled, and its
// result is held in the output register until taken. The pipeline stages are
// the four multiply stages, each followed by a rounding and saturation stage,
// plus the wall stage that drives the output.
// All stages advance together: the pipeline moves whenever the output register
// is empty or being taken, so a stall at the output freezes every stage.
// Reset clears the stage valid bits and loads the register defaults; the
// configuration port is always ready.
module charged_particle_rotation_push_unit
	import cpr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x[23:0], pos_y[47:24], vel_x[71:48], vel_y[95:72],
	// kick_x[110:96], kick_y[125:111], zero padding[127:126]
	input  logic [127:0] s_axis_tdata,
	// is_negative[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_pos_x[23:0], new_pos_y[47:24], new_vel_x[71:48], new_vel_y[95:72]
	output logic [95:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	cpr_cfg_t cfg;

	cpr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Configuration fields as signed operands.
	logic signed [16:0] dt_s;
	trig_t              cos_c;
	trig_t              sin_c;
	logic signed [16:0] sin_e;
	val_t               x_min_c;
	val_t               x_max_c;
	val_t               y_min_c;
	val_t               y_max_c;

	assign dt_s    = $signed({1'b0, cfg.step_dt});
	assign cos_c   = cfg.rot_cos;
	assign sin_c   = cfg.rot_sin;
	assign sin_e   = 17'(sin_c);
	assign x_min_c = cfg.x_min;
	assign x_max_c = cfg.x_max;
	assign y_min_c = cfg.y_min;
	assign y_max_c = cfg.y_max;

	// Input fields.
	val_t  pos_x_in;
	val_t  pos_y_in;
	val_t  vel_x_in;
	val_t  vel_y_in;
	kick_t kick_x_in;
	kick_t kick_y_in;

	assign pos_x_in  = s_axis_tdata[23:0];
	assign pos_y_in  = s_axis_tdata[47:24];
	assign vel_x_in  = s_axis_tdata[71:48];
	assign vel_y_in  = s_axis_tdata[95:72];
	assign kick_x_in = s_axis_tdata[110:96];
	assign kick_y_in = s_axis_tdata[125:111];

	// The whole pipeline advances when the output register can move.
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	assign adv           = !vld_s9 || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// Stage payload registers.
	logic signed [31:0] kprod_x_s1, kprod_y_s1;
	val_t               vel_x_s1, vel_y_s1;
	val_t               vk_x_s2, vk_y_s2;
	logic signed [41:0] dprod_x_s3, dprod_y_s3;
	val_t               vd_x_s4, vd_y_s4;
	logic signed [41:0] pxc_s5, pys_s5, pxs_s5, pyc_s5;
	val_t               vr_x_s6, vr_y_s6;
	val_t               vr_x_s7, vr_y_s7;
	logic signed [41:0] mprod_x_s7, mprod_y_s7;
	val_t               vr_x_s8, vr_y_s8;
	val_t               pm_x_s8, pm_y_s8;
	val_t               pos_x_s1, pos_x_s2, pos_x_s3, pos_x_s4, pos_x_s5, pos_x_s6, pos_x_s7;
	val_t               pos_y_s1, pos_y_s2, pos_y_s3, pos_y_s4, pos_y_s5, pos_y_s6, pos_y_s7;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	pv_t                out_x_s9, out_y_s9;

	// The rotation sense follows the charge: a hole sees the sine negated.
	logic signed [16:0] sn_s4;
	pv_t                wall_x, wall_y;

	assign sn_s4  = neg_s4 ? sin_e : -sin_e;
	assign wall_x = wall(pm_x_s8, vr_x_s8, x_min_c, x_max_c);
	assign wall_y = wall(pm_y_s8, vr_y_s8, y_min_c, y_max_c);

	always_ff @(posedge clk) begin
		if (adv) begin
			// Kick scaled by the time step.
			kprod_x_s1 <= kick_x_in * dt_s;
			kprod_y_s1 <= kick_y_in * dt_s;
			vel_x_s1   <= vel_x_in;
			vel_y_s1   <= vel_y_in;
			pos_x_s1   <= pos_x_in;
			pos_y_s1   <= pos_y_in;
			neg_s1     <= s_axis_tuser;

			// Kick added to the velocity.
			vk_x_s2  <= sat_val(WIDE_W'(vel_x_s1) + rnd_sh(WIDE_W'(kprod_x_s1), DT_SHIFT));
			vk_y_s2  <= sat_val(WIDE_W'(vel_y_s1) + rnd_sh(WIDE_W'(kprod_y_s1), DT_SHIFT));
			pos_x_s2 <= pos_x_s1;
			pos_y_s2 <= pos_y_s1;
			neg_s2   <= neg_s1;

			// Damping product.
			dprod_x_s3 <= vk_x_s2 * DAMP_Q16;
			dprod_y_s3 <= vk_y_s2 * DAMP_Q16;
			pos_x_s3   <= pos_x_s2;
			pos_y_s3   <= pos_y_s2;
			neg_s3     <= neg_s2;

			vd_x_s4  <= sat_val(rnd_sh(WIDE_W'(dprod_x_s3), DAMP_SHIFT));
			vd_y_s4  <= sat_val(rnd_sh(WIDE_W'(dprod_y_s3), DAMP_SHIFT));
			pos_x_s4 <= pos_x_s3;
			pos_y_s4 <= pos_y_s3;
			neg_s4   <= neg_s3;

			// Four rotation products.
			pxc_s5   <= vd_x_s4 * cos_c;
			pys_s5   <= vd_y_s4 * sn_s4;
			pxs_s5   <= vd_x_s4 * sn_s4;
			pyc_s5   <= vd_y_s4 * cos_c;
			pos_x_s5 <= pos_x_s4;
			pos_y_s5 <= pos_y_s4;

			vr_x_s6  <= sat_val(rnd_sh(WIDE_W'(pxc_s5) - WIDE_W'(pys_s5), TRIG_SHIFT));
			vr_y_s6  <= sat_val(rnd_sh(WIDE_W'(pxs_s5) + WIDE_W'(pyc_s5), TRIG_SHIFT));
			pos_x_s6 <= pos_x_s5;
			pos_y_s6 <= pos_y_s5;

			// Displacement over one frame.
			mprod_x_s7 <= vr_x_s6 * dt_s;
			mprod_y_s7 <= vr_y_s6 * dt_s;
			vr_x_s7    <= vr_x_s6;
			vr_y_s7    <= vr_y_s6;
			pos_x_s7   <= pos_x_s6;
			pos_y_s7   <= pos_y_s6;

			pm_x_s8 <= sat_val(WIDE_W'(pos_x_s7) + rnd_sh(WIDE_W'(mprod_x_s7), DT_SHIFT));
			pm_y_s8 <= sat_val(WIDE_W'(pos_y_s7) + rnd_sh(WIDE_W'(mprod_y_s7), DT_SHIFT));
			vr_x_s8 <= vr_x_s7;
			vr_y_s8 <= vr_y_s7;

			// Wall clamp and reflection into the output register.
			out_x_s9 <= wall_x;
			out_y_s9 <= wall_y;
		end
	end

	assign m_axis_tdata = {out_y_s9.vel, out_x_s9.vel, out_y_s9.pos, out_x_s9.pos};

	// An accepted item always occupies the first stage on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s1)
		else $error("accepted item did not enter the first stage");

	// An item in the last compute stage reaches the output when the pipe advances.
	a_s8_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s8 && adv) |=> m_axis_tvalid)
		else $error("item was lost between the last stage and the output");

	// With no item in the last compute stage, an advance leaves the output without a result.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!vld_s8 && adv) |=> !m_axis_tvalid)
		else $error("output became valid without an item in flight");

endmodule
